@@ rtl/keyboard_beeper_io_port_top_defines.svh @@
// ---------------------------------------------------------------------------
// keyboard_beeper_io_port_top_defines.svh
// Assertion macros used by the keyboard / beeper port checker.
// ---------------------------------------------------------------------------
`ifndef KEYBOARD_BEEPER_IO_PORT_TOP_DEFINES_SVH
`define KEYBOARD_BEEPER_IO_PORT_TOP_DEFINES_SVH

// checked property, ignored while reset is asserted
`define KBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds during reset
`define KBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/kbp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbp_pkg
// Types and constants of the keyboard / beeper I/O port.
// ---------------------------------------------------------------------------
package kbp_pkg;

  // word kinds
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_ROW   = 2'd2
  } action_e;

  localparam int ROW_COUNT      = 8;
  localparam int ROW_IDX_W      = $clog2(ROW_COUNT);
  localparam int BYTE_W         = 8;
  localparam int ADDR_W         = 16;
  localparam int TACTS_W        = 32;
  localparam int BORDER_W       = 3;
  localparam int BEEPER_W       = 2;

  // address decode
  localparam int PORT_SEL_BIT   = 0;
  localparam int ROW_SEL_LSB    = 8;

  // write byte layout
  localparam int MIC_BIT        = 3;
  localparam int EAR_BIT        = 4;
  localparam logic [BORDER_W-1:0] BORDER_RESET = 3'd7;

  // read byte layout
  localparam logic [BYTE_W-1:0] READ_KEY_MASK = 8'hBF;
  localparam int EAR_SENSE_BIT  = 6;

  // capacitor charge model
  localparam int CHARGE_LIMIT   = 700;
  localparam int CHARGE_MAX     = 2800;
  localparam int CHARGE_SHIFT   = 2;
  localparam int CHARGE_W       = $clog2(CHARGE_MAX + 1);

  // one input word
  typedef struct packed {
    action_e                action;
    logic [ADDR_W-1:0]      address;
    logic [BYTE_W-1:0]      value;
    logic [TACTS_W-1:0]     tacts;
    logic [BYTE_W-1:0]      floating_bus;
    logic [ROW_IDX_W-1:0]   key_row;
    logic [BYTE_W-1:0]      key_bits;
  } item_t;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0]      read_data;
    logic                   audio_changed;
    logic                   ear_level;
    logic                   mic_level;
    logic [BEEPER_W-1:0]    beeper_level;
    logic [BORDER_W-1:0]    border_color;
  } res_t;

endpackage

@@ rtl/keyboard_beeper_io_port_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyboard_beeper_io_port_top
// Keyboard / beeper I/O port: input register, port logic, result register.
// ---------------------------------------------------------------------------
// One word per clock cycle while the output is not stalled; an accepted
// word waits in the input register until the result register can take its
// result. Combinational logic (key-row or, EAR charge subtract and compare)
// forms the result and next port state, loaded together into the result and
// state registers, so the next word already sees the updated state. The input
// side keeps accepting while a result waits, as long as the input register
// can move on; a stalled output holds one result and one pending word.
module keyboard_beeper_io_port_top
  import kbp_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [BYTE_W-1:0]    value_i,
  input  logic [TACTS_W-1:0]   tacts_i,
  input  logic [BYTE_W-1:0]    floating_bus_i,
  input  logic [ROW_IDX_W-1:0] key_row_i,
  input  logic [BYTE_W-1:0]    key_bits_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    read_data_o,
  output logic                 audio_changed_o,
  output logic                 ear_level_o,
  output logic                 mic_level_o,
  output logic [BEEPER_W-1:0]  beeper_level_o,
  output logic [BORDER_W-1:0]  border_color_o
);

  logic  in_valid_q, in_valid_d;
  item_t item_q;
  logic  out_valid_q, out_valid_d;
  res_t  res_q;
  res_t  res_d;
  logic  in_take;
  logic  advance;

  // handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action       <= action_e'(action_i);
      item_q.address      <= address_i;
      item_q.value        <= value_i;
      item_q.tacts        <= tacts_i;
      item_q.floating_bus <= floating_bus_i;
      item_q.key_row      <= key_row_i;
      item_q.key_bits     <= key_bits_i;
    end
  end

  // port logic and state
  kbp_port_state #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_port_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_data;
  assign audio_changed_o = res_q.audio_changed;
  assign ear_level_o     = res_q.ear_level;
  assign mic_level_o     = res_q.mic_level;
  assign beeper_level_o  = res_q.beeper_level;
  assign border_color_o  = res_q.border_color;

endmodule

@@ rtl/kbp_ear_sense.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbp_ear_sense
// EAR input level as seen by a read: the capacitor keeps it high for four
// times the last high time after a fall, capped at 2800 T-states.
// ---------------------------------------------------------------------------
module kbp_ear_sense
  import kbp_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  ear_i,
  input  logic [TIME_WIDTH-1:0] rose_i,
  input  logic [TIME_WIDTH-1:0] fell_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  output logic                  sensed_o
);

  logic [TIME_WIDTH-1:0] charge;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CHARGE_W-1:0]   hold;
  logic                  charge_nz;
  logic                  charge_big;
  logic                  in_window;

  // charge time and time since the fall, both wrapping
  assign charge     = fell_i - rose_i;
  assign elapsed    = now_i - fell_i;
  assign charge_nz  = |charge;
  assign charge_big = charge > TIME_WIDTH'(CHARGE_LIMIT);

  // hold time: scaled charge or the cap
  assign hold = charge_big ? CHARGE_W'(CHARGE_MAX)
                           : {charge[CHARGE_W-CHARGE_SHIFT-1:0], {CHARGE_SHIFT{1'b0}}};

  // elapsed below hold time
  assign in_window = ~(|elapsed[TIME_WIDTH-1:CHARGE_W]) && (elapsed[CHARGE_W-1:0] < hold);

  assign sensed_o = ear_i | (charge_nz & in_window);

endmodule

@@ rtl/kbp_port_state.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbp_port_state
// Port state (border, MIC, EAR, edge times, key rows) and the logic that
// turns one word into its result and the next state.
// ---------------------------------------------------------------------------
module kbp_port_state
  import kbp_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  output res_t  res_o
);

  logic [BORDER_W-1:0]   border_q, border_d;
  logic                  ear_q, ear_d;
  logic                  mic_q, mic_d;
  logic [TIME_WIDTH-1:0] rose_q, rose_d;
  logic [TIME_WIDTH-1:0] fell_q, fell_d;
  logic [BYTE_W-1:0]     rows_q [ROW_COUNT];
  logic [BYTE_W-1:0]     rows_d [ROW_COUNT];

  logic [TIME_WIDTH-1:0] now;
  logic                  sensed;
  logic [BYTE_W-1:0]     sel;
  logic [BYTE_W-1:0]     status;
  logic [BYTE_W-1:0]     key_byte;
  logic                  even_port;
  logic                  next_mic;
  logic                  next_ear;
  logic [BYTE_W-1:0]     read_data;
  logic                  changed;

  assign now       = TIME_WIDTH'(item_i.tacts);
  assign even_port = ~item_i.address[PORT_SEL_BIT];
  assign next_mic  = item_i.value[MIC_BIT];
  assign next_ear  = item_i.value[EAR_BIT];

  kbp_ear_sense #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ear_sense (
    .ear_i    (ear_q),
    .rose_i   (rose_q),
    .fell_i   (fell_q),
    .now_i    (now),
    .sensed_o (sensed)
  );

  // or of the selected key rows
  assign sel = ~item_i.address[ROW_SEL_LSB +: BYTE_W];
  always_comb begin
    status = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (sel[r]) begin
        status = status | rows_q[r];
      end
    end
  end

  // keyboard byte with sensed ear in its slot
  always_comb begin
    key_byte = ~status & READ_KEY_MASK;
    key_byte[EAR_SENSE_BIT] = sensed;
  end

  // next state and result
  always_comb begin
    border_d  = border_q;
    ear_d     = ear_q;
    mic_d     = mic_q;
    rose_d    = rose_q;
    fell_d    = fell_q;
    rows_d    = rows_q;
    read_data = '0;
    changed   = 1'b0;
    case (item_i.action)
      ACT_READ: begin
        read_data = even_port ? key_byte : item_i.floating_bus;
      end
      ACT_WRITE: begin
        if (even_port) begin
          border_d = item_i.value[BORDER_W-1:0];
          mic_d    = next_mic;
          ear_d    = next_ear;
          changed  = (next_ear != ear_q) || (next_mic != mic_q);
          if (ear_q && !next_ear) begin
            fell_d = now;
          end
          if (!ear_q && next_ear) begin
            rose_d = now;
          end
        end
      end
      ACT_ROW: begin
        rows_d[item_i.key_row] = item_i.key_bits;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.read_data     = read_data;
    res_o.audio_changed = changed;
    res_o.ear_level     = ear_d;
    res_o.mic_level     = mic_d;
    res_o.beeper_level  = {ear_d, mic_d};
    res_o.border_color  = border_d;
  end

  // state registers, advance once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= BORDER_RESET;
      ear_q    <= 1'b0;
      mic_q    <= 1'b0;
      rose_q   <= '0;
      fell_q   <= '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
        rows_q[r] <= '0;
      end
    end else if (step_i) begin
      border_q <= border_d;
      ear_q    <= ear_d;
      mic_q    <= mic_d;
      rose_q   <= rose_d;
      fell_q   <= fell_d;
      rows_q   <= rows_d;
    end
  end

endmodule

@@ rtl/kbp_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbp_checker
// Port-level checks of the keyboard / beeper I/O port, bound to the top.
// ---------------------------------------------------------------------------
`include "keyboard_beeper_io_port_top_defines.svh"

module kbp_checker
  import kbp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [BYTE_W-1:0]    read_data_o,
  input logic                 audio_changed_o,
  input logic                 ear_level_o,
  input logic                 mic_level_o,
  input logic [BEEPER_W-1:0]  beeper_level_o
);

  // no result word in the cycle after a reset cycle
  `KBP_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

  // a result word stays until taken
  `KBP_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // an empty result register never blocks the input
  `KBP_ASSERT(a_in_ready, clk_i, rst_ni,
              !out_valid_o |-> in_ready_o, "input blocked while empty")

  // beeper level mirrors ear and mic
  `KBP_ASSERT(a_beeper, clk_i, rst_ni,
              out_valid_o |-> (beeper_level_o == {ear_level_o, mic_level_o}), "beeper mismatch")

  // an audio change only comes from a write, which reads nothing
  `KBP_ASSERT(a_chg_rd, clk_i, rst_ni,
              out_valid_o && audio_changed_o |-> read_data_o == '0, "change on read")

endmodule

bind keyboard_beeper_io_port_top kbp_checker u_kbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .audio_changed_o (audio_changed_o),
  .ear_level_o     (ear_level_o),
  .mic_level_o     (mic_level_o),
  .beeper_level_o  (beeper_level_o)
);

@@ dv/keyboard_beeper_io_port_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyboard_beeper_io_port_top_tb
// Self-checking bench for the keyboard / beeper I/O port. A queue of port
// reads, writes and key-row updates is driven through the valid/ready input,
// each accepted word is run through a local model of the port state, and
// every result word is checked field by field against the oldest prediction.
// Both sides idle at random, and the receiver holds off once to fill the port.
// ---------------------------------------------------------------------------
module keyboard_beeper_io_port_top_tb
  import kbp_pkg::*;
();

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int RANDOM_WORDS = 1600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;

  typedef struct {
    item_t       word;
    int unsigned gap;
  } stim_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  out_ready_i = 1'b0;
  item_t tx_word = '0;
  logic  in_ready_o, out_valid_o;
  res_t  rx_word;

  stim_t stim_q[$];
  res_t  port_res_q[$];

  logic  in_acc = 1'b0;
  logic  out_acc = 1'b0;
  int    n_total = 0;
  int    n_taken = 0;
  int    n_results = 0;
  int    n_errors = 0;
  int    gap_left = 0;
  int    rx_wait = 0;
  bit    rx_calm = 1'b0;
  bit    hold_done = 1'b0;
  int    idle_cycles = 0;

  // port state as seen by the predictor
  logic [BORDER_W-1:0] st_border;
  logic                st_ear, st_mic;
  logic [BEEPER_W-1:0] st_beeper;
  logic [TACTS_W-1:0]  st_rose, st_fell;
  logic [BYTE_W-1:0]   st_rows [ROW_COUNT];

  keyboard_beeper_io_port_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (tx_word.action),
    .address_i       (tx_word.address),
    .value_i         (tx_word.value),
    .tacts_i         (tx_word.tacts),
    .floating_bus_i  (tx_word.floating_bus),
    .key_row_i       (tx_word.key_row),
    .key_bits_i      (tx_word.key_bits),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (rx_word.read_data),
    .audio_changed_o (rx_word.audio_changed),
    .ear_level_o     (rx_word.ear_level),
    .mic_level_o     (rx_word.mic_level),
    .beeper_level_o  (rx_word.beeper_level),
    .border_color_o  (rx_word.border_color)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic port_reset();
    st_border = BORDER_RESET;
    st_ear    = 1'b0;
    st_mic    = 1'b0;
    st_beeper = '0;
    st_rose   = '0;
    st_fell   = '0;
    for (int r = 0; r < ROW_COUNT; r++) st_rows[r] = '0;
  endtask

  // advance the port state by one word and form its result
  function automatic res_t step_port(item_t w);
    res_t                res;
    logic [BYTE_W-1:0]   keys;
    logic [TACTS_W-1:0]  charge, window;
    logic                sensed, next_ear, next_mic;
    res = '0;
    case (w.action)
      ACT_READ: begin
        if (w.address[PORT_SEL_BIT]) begin
          res.read_data = w.floating_bus;
        end else begin
          keys = '0;
          for (int r = 0; r < ROW_COUNT; r++)
            if (!w.address[ROW_SEL_LSB + r]) keys |= st_rows[r];
          sensed = st_ear;
          // capacitor still reads high for a while after EAR falls
          if (!st_ear) begin
            charge = st_fell - st_rose;
            if (charge != 0) begin
              window = (charge > CHARGE_LIMIT) ? TACTS_W'(CHARGE_MAX) : charge << CHARGE_SHIFT;
              sensed = ((w.tacts - st_fell) < window);
            end
          end
          res.read_data = (~keys & READ_KEY_MASK);
          res.read_data[EAR_SENSE_BIT] = sensed;
        end
      end
      ACT_WRITE: begin
        if (!w.address[PORT_SEL_BIT]) begin
          st_border = w.value[BORDER_W-1:0];
          next_mic  = w.value[MIC_BIT];
          next_ear  = w.value[EAR_BIT];
          res.audio_changed = (next_ear != st_ear) || (next_mic != st_mic);
          st_mic    = next_mic;
          st_beeper = {next_ear, next_mic};
          if (st_ear && !next_ear) begin
            st_fell = w.tacts;
            st_ear  = 1'b0;
          end else if (!st_ear && next_ear) begin
            st_rose = w.tacts;
            st_ear  = 1'b1;
          end
        end
      end
      ACT_ROW: st_rows[w.key_row] = w.key_bits;
      default: ;
    endcase
    res.ear_level    = st_ear;
    res.mic_level    = st_mic;
    res.beeper_level = st_beeper;
    res.border_color = st_border;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
    n_errors++;
  endtask

  function automatic item_t make_word(logic [1:0] act, logic [ADDR_W-1:0] addr,
                                      logic [BYTE_W-1:0] val, logic [TACTS_W-1:0] t,
                                      logic [BYTE_W-1:0] fbus, logic [ROW_IDX_W-1:0] row,
                                      logic [BYTE_W-1:0] bits);
    item_t w;
    w.action       = action_e'(act);
    w.address      = addr;
    w.value        = val;
    w.tacts        = t;
    w.floating_bus = fbus;
    w.key_row      = row;
    w.key_bits     = bits;
    return w;
  endfunction

  task automatic queue_word(item_t w, int unsigned gap);
    stim_t s;
    s.word = w;
    s.gap  = gap;
    stim_q.push_back(s);
  endtask

  // sample both handshakes, predict accepted words, check result words
  always @(posedge clk_i) begin
    res_t want;
    in_acc  <= in_valid_i && in_ready_o;
    out_acc <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        port_res_q.push_back(step_port(tx_word));
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (port_res_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(rx_word), 0);
        end else begin
          want = port_res_q.pop_front();
          if (rx_word.read_data !== want.read_data)
            report_mismatch("read_data", 32'(rx_word.read_data), 32'(want.read_data));
          if (rx_word.audio_changed !== want.audio_changed)
            report_mismatch("audio_changed", 32'(rx_word.audio_changed),
                            32'(want.audio_changed));
          if (rx_word.ear_level !== want.ear_level)
            report_mismatch("ear_level", 32'(rx_word.ear_level), 32'(want.ear_level));
          if (rx_word.mic_level !== want.mic_level)
            report_mismatch("mic_level", 32'(rx_word.mic_level), 32'(want.mic_level));
          if (rx_word.beeper_level !== want.beeper_level)
            report_mismatch("beeper_level", 32'(rx_word.beeper_level),
                            32'(want.beeper_level));
          if (rx_word.border_color !== want.border_color)
            report_mismatch("border_color", 32'(rx_word.border_color),
                            32'(want.border_color));
        end
        n_results++;
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
          $display("keyboard_beeper_io_port_top_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // input driver, one word from the queue at a time
  always @(negedge clk_i) begin
    stim_t s;
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (stim_q.size() > 0) begin
          s = stim_q.pop_front();
          tx_word <= s.word;
          in_valid_i <= 1'b1;
          gap_left <= s.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output receiver, random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        if (!hold_done && n_results >= HOLD_AT) begin
          rx_wait = HOLD_CYCLES;
          hold_done = 1'b1;
        end else begin
          rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
        end
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [TACTS_W-1:0]  now_t;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   hi;
    logic [1:0]          act;
    int                  pick, counted;
    bit                  tx_calm;
    int unsigned         gap;

    port_reset();

    // directed: extremes, every action, charge window edges, ignored words
    queue_word(make_word(ACT_READ,    16'h00FE, 8'h00, 32'd0, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFF, 8'hFF, 32'd1, 8'hFF, 3'd7, 8'hFF), 0);
    queue_word(make_word(ACT_READ,    16'h0001, 8'h00, 32'd2, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_ROW,     16'h0000, 8'h00, 32'd3, 8'h00, 3'd0, 8'hFF), 0);
    queue_word(make_word(ACT_ROW,     16'hFFFF, 8'hFF, 32'd4, 8'hFF, 3'd7, 8'hA5), 0);
    queue_word(make_word(ACT_READ,    16'hFEFE, 8'h00, 32'd5, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'h7FFE, 8'h00, 32'd6, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd7, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'h0000, 8'h00, 32'd8, 8'h00, 3'd0, 8'h00), 0);
    // short high time: window is four times the high time
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h10, 32'd1000, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h00, 32'd1100, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd1300, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd1500, 8'h00, 3'd0, 8'h00), 0);
    // long high time: window capped
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h18, 32'd2000, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h07, 32'd3000, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd5799, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd5800, 8'h00, 3'd0, 8'h00), 0);
    // rise and fall at the same time: no charge
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h10, 32'd6000, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_WRITE,   16'h00FE, 8'h00, 32'd6000, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'd6001, 8'h00, 3'd0, 8'h00), 0);
    // odd-address write and unknown action change nothing
    queue_word(make_word(ACT_WRITE,   16'h00FF, 8'hFF, 32'd6002, 8'hFF, 3'd7, 8'hFF), 0);
    queue_word(make_word(ACT_UNKNOWN, 16'hFFFE, 8'hFF, 32'd6003, 8'hFF, 3'd7, 8'hFF), 0);
    // edges across the counter wrap
    queue_word(make_word(ACT_WRITE,   16'hFFFE, 8'hFF, 32'hFFFF_FF00, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_WRITE,   16'hFFFE, 8'h00, 32'h0000_0010, 8'h00, 3'd0, 8'h00), 0);
    queue_word(make_word(ACT_READ,    16'hFFFE, 8'h00, 32'h0000_0100, 8'h00, 3'd0, 8'h00), 0);

    // random: mostly well-formed traffic on a running T-state count
    now_t   = 32'h0000_0200;
    counted = 0;
    tx_calm = 1'b0;
    while (counted < RANDOM_WORDS) begin
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 39) == 0) now_t = $urandom;
      else now_t += $urandom_range(0, 1200);
      addr = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        act = ACT_READ;
        case ($urandom_range(0, 3))
          0: hi = 8'($urandom);
          1: hi = ~(8'd1 << $urandom_range(0, 7));
          2: hi = 8'hFF;
          default: hi = 8'h00;
        endcase
        addr[15:8] = hi;
        addr[PORT_SEL_BIT] = ($urandom_range(0, 4) == 0);
      end else if (pick < 75) begin
        act = ACT_WRITE;
        addr[PORT_SEL_BIT] = ($urandom_range(0, 9) == 0);
      end else if (pick < 95) begin
        act = ACT_ROW;
      end else begin
        act = ACT_UNKNOWN;
      end
      gap = tx_calm ? 0 : $urandom_range(0, 19);
      queue_word(make_word(act, addr, 8'($urandom), now_t, 8'($urandom),
                           3'($urandom), 8'($urandom)), gap);
      counted++;
    end
    n_total = stim_q.size();

    // hold reset, then release it at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for all words in, all results out, then let the pipeline settle
    while (n_taken < n_total) @(posedge clk_i);
    while (port_res_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (port_res_q.size() != 0) report_mismatch("missing words", 32'(port_res_q.size()), 0);

    if (n_errors == 0) begin
      $display("keyboard_beeper_io_port_top_tb: PASS");
    end else begin
      $display("keyboard_beeper_io_port_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kbp_pkg.sv
rtl/kbp_ear_sense.sv
rtl/kbp_port_state.sv
rtl/keyboard_beeper_io_port_top.sv
rtl/kbp_checker.sv
dv/keyboard_beeper_io_port_top_tb.sv
